/* rtl/lru_key_value_cache_defines.svh */
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// A condition that holds at every clock edge.
`define LKVC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define LKVC_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, codes and the entry type shared by the cache cells and the top level.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_SET = 1'b1;

	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [CAP_W-1:0]  CAPACITY_RESET = 5'd16;
	localparam logic [DATA_W-1:0] MISS_VALUE     = '1;

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} entry_t;

endpackage

/* rtl/lkvc_cell.sv */
// ----------------------------------------------------------------------------
// LRU key-value cache cell
// One place in the recency chain: holds an entry, compares it with the looked
// up key, and takes its neighbour's entry when the chain shifts.
// ----------------------------------------------------------------------------
module lkvc_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  logic signed [lkvc_pkg::DATA_W-1:0] cmp_key,
	input  lkvc_pkg::entry_t                 entry_in,
	output lkvc_pkg::entry_t                 entry_out,
	output logic                             match_s2
);
	import lkvc_pkg::*;

	logic                     valid_q;
	logic signed [DATA_W-1:0] key_q;
	logic signed [DATA_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			match_s2 <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= entry_in.valid;
			end
			match_s2 <= valid_q && (key_q == cmp_key);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q   <= entry_in.key;
			value_q <= entry_in.value;
		end
	end

	assign entry_out = '{valid: valid_q, key: key_q, value: value_q};

endmodule

/* rtl/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store kept as a chain of cells in recency order.
// ----------------------------------------------------------------------------
// A word on the input channel (in_valid/in_ready) carries cmd, key and data_in.
// A get returns one word on the output channel (out_valid/out_ready) with hit
// and data_out; data_out is all ones on a miss. A set returns nothing.
// Cell 0 holds the most recent entry. A hit or an insertion shifts the cells
// ahead of the affected place down by one and writes the entry into cell 0;
// once the count reaches the capacity an insertion drops the last valid cell.
// Each word passes through a compare state, in which every cell checks its
// key against the looked-up key, and then a shift state. A new word can be
// taken in the shift state of the last one, and a get result is written to
// the output register as its shift is done. A result waits in the output
// register while out_ready is low; a following get then holds in its shift
// state until the register is free, while a set carries on. Reset empties
// the cache at once and sets the capacity register to 16; no clearing pass
// is needed. The capacity register sits at address 0 of the APB port. The
// user must write it only while the block is idle; no logic enforces this.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               cmd,
	input  logic signed [lkvc_pkg::DATA_W-1:0]  key,
	input  logic signed [lkvc_pkg::DATA_W-1:0]  data_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               hit,
	output logic signed [lkvc_pkg::DATA_W-1:0]  data_out,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lkvc_pkg::PADDR_W-1:0]        paddr,
	input  logic [lkvc_pkg::PDATA_W-1:0]        pwdata,
	output logic [lkvc_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);
	import lkvc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPD
	} state_t;

	state_t                   state_q;
	logic                     cmd_s1;
	logic signed [DATA_W-1:0] key_s1;
	logic signed [DATA_W-1:0] data_s1;
	logic [CNT_W-1:0]         count_q;
	logic [CAP_W-1:0]         capacity_q;
	logic                     out_valid_q;
	logic                     hit_q;
	logic signed [DATA_W-1:0] data_out_q;

	entry_t                   ents [ENTRIES];
	entry_t                   head;
	logic [ENTRIES-1:0]       match;
	logic [ENTRIES-1:0]       load;
	logic [ENTRIES-1:0]       valid_vec;
	logic                     hit_any;
	logic signed [DATA_W-1:0] hit_value;
	logic [CMP_W-1:0]         cap_eff;
	logic                     evict;
	logic                     do_upd;
	logic                     in_accept;
	logic                     cfg_write;

	assign in_accept = in_valid && in_ready;
	assign do_upd    = (state_q == ST_UPD) &&
		((cmd_s1 == CMD_SET) || !out_valid_q || out_ready);
	assign in_ready  = (state_q == ST_IDLE) || do_upd;

	always_comb begin
		hit_any   = |match;
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				hit_value = hit_value | ents[i].value;
			end
			valid_vec[i] = ents[i].valid;
		end
	end

	always_comb begin
		cap_eff = CMP_W'(capacity_q);
		if (cap_eff == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_eff > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end
		evict = CMP_W'(count_q) >= cap_eff;
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_any) begin
				load[i] = do_upd && (|(match >> i));
			end else begin
				load[i] = do_upd && (cmd_s1 == CMD_SET) &&
					((CNT_W'(i) < count_q) || (!evict && (CNT_W'(i) == count_q)));
			end
		end
	end

	assign head = '{valid: 1'b1, key: key_s1,
		value: (cmd_s1 == CMD_SET) ? data_s1 : hit_value};

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		if (g == 0) begin : g_head
			lkvc_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.load      (load[g]),
				.cmp_key   (key_s1),
				.entry_in  (head),
				.entry_out (ents[g]),
				.match_s2  (match[g])
			);
		end else begin : g_body
			lkvc_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.load      (load[g]),
				.cmp_key   (key_s1),
				.entry_in  (ents[g-1]),
				.entry_out (ents[g]),
				.match_s2  (match[g])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1  <= cmd;
			key_s1  <= key;
			data_s1 <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			data_out_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (do_upd) begin
						state_q <= in_accept ? ST_LOOK : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (do_upd && (cmd_s1 == CMD_GET)) begin
				out_valid_q <= 1'b1;
				hit_q       <= hit_any;
				data_out_q  <= hit_any ? hit_value : MISS_VALUE;
			end
		end
	end

	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			capacity_q <= CAPACITY_RESET;
		end else begin
			if (do_upd && (cmd_s1 == CMD_SET) && !hit_any && !evict) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cfg_write) begin
				capacity_q <= pwdata[CAP_W-1:0];
			end
		end
	end

	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_q) : '0;
	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign data_out  = data_out_q;

	`LKVC_ASSERT_IMPLY(a_match_unique, state_q == ST_UPD, $onehot0(match), "key held twice")
	`LKVC_ASSERT_ALWAYS(a_count_valid, $countones(valid_vec) == count_q, "count out of step")
	`LKVC_ASSERT_ALWAYS(a_count_max, count_q <= CNT_W'(ENTRIES), "count above entries")
	`LKVC_ASSERT_NEXT(a_accept_look, in_valid && in_ready, state_q == ST_LOOK, "no compare")

endmodule

/* tb/tb_lru_key_value_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and set words through the valid/ready input channel with random
// gaps, stalls the result channel at random and checks every returned word
// against a recency model or typed table values. A short table of directed
// words and register writes precedes random phases at several capacities.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
	import lkvc_pkg::*;

	localparam int REG_SPARE     = 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES        = 13;
	localparam int PHASE_WORDS   = 150;
	localparam int DIR_ROWS      = 27;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct {
		logic              hit;
		logic [DATA_W-1:0] data;
	} read_result_t;

	typedef struct {
		row_kind_t         kind;
		int                reg_idx;
		logic              cmd;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
		bit                typed;
		logic              want_hit;
		logic [DATA_W-1:0] want_data;
	} dir_row_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               cmd       = CMD_GET;
	logic [DATA_W-1:0]  key       = '0;
	logic [DATA_W-1:0]  data_in   = '0;
	logic               out_ready = 1'b0;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	wire                in_ready;
	wire                out_valid;
	wire                hit;
	wire  [DATA_W-1:0]  data_out;
	wire  [PDATA_W-1:0] prdata;
	wire                pready;

	int unsigned  idle_pct = 33;
	int unsigned  mismatch_count = 0;
	read_result_t pending_reads [$];

	logic [DATA_W-1:0] cache_key [ENTRIES];
	logic [DATA_W-1:0] cache_val [ENTRIES];
	bit                cache_live [ENTRIES];
	int unsigned       cache_age [ENTRIES];
	int unsigned       cache_fill = 0;
	logic [CAP_W-1:0]  cap_reg = CAPACITY_RESET;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_WORD, 0, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_WORD, 0, CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
		'{ROW_WORD, 0, CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
		'{ROW_WORD, 0, CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{ROW_WORD, 0, CMD_SET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
		'{ROW_REG, REG_CAPACITY, CMD_GET, 32'h0, 32'd1, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_SET, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_GET, 32'h5555_5555, 32'h0000_0000, 1'b1, 1'b1, 32'hAAAA_AAAA},
		'{ROW_WORD, 0, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_REG, REG_CAPACITY, CMD_GET, 32'h0, 32'd0, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_SET, 32'h0000_0001, 32'h0000_0002, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_REG, REG_SPARE, CMD_GET, 32'h0, 32'd3, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_SET, 32'h0000_0002, 32'h0000_0003, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_GET, 32'h5555_5555, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_REG, REG_CAPACITY, CMD_GET, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_SET, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_REG, REG_CAPACITY, CMD_GET, 32'h0, 32'd16, 1'b0, 1'b0, 32'h0},
		'{ROW_WORD, 0, CMD_GET, 32'hAAAA_AAAA, 32'h0000_0000, 1'b1, 1'b1, 32'h5555_5555},
		'{ROW_WORD, 0, CMD_GET, 32'h1234_5678, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE}
	};

	lru_key_value_cache i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.key       (key),
		.data_in   (data_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.data_out  (data_out),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("lru_key_value_cache verification failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic void promote(input int e);
		int unsigned r;
		r = cache_age[e];
		for (int i = 0; i < ENTRIES; i++) begin
			if (cache_live[i] && cache_age[i] < r)
				cache_age[i]++;
		end
		cache_age[e] = 0;
	endfunction

	function automatic void cache_access(input logic c, input logic [DATA_W-1:0] k,
			input logic [DATA_W-1:0] v, output bit produced, output read_result_t res);
		int          e;
		int          slot;
		int          victim;
		int unsigned cap;
		int unsigned best;
		e = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (e < 0 && cache_live[i] && cache_key[i] == k)
				e = i;
		end
		produced = (c == CMD_GET);
		res.hit  = 1'b0;
		res.data = MISS_VALUE;
		if (c == CMD_SET) begin
			if (e >= 0) begin
				cache_val[e] = v;
				promote(e);
			end else begin
				cap = cap_reg;
				if (cap == 0)
					cap = 1;
				if (cap > ENTRIES)
					cap = ENTRIES;
				if (cache_fill >= cap) begin
					victim = -1;
					best   = 0;
					for (int i = 0; i < ENTRIES; i++) begin
						if (cache_live[i] && (victim < 0 || cache_age[i] > best)) begin
							victim = i;
							best   = cache_age[i];
						end
					end
					if (victim >= 0) begin
						cache_live[victim] = 1'b0;
						cache_fill--;
					end
				end
				slot = -1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot < 0 && !cache_live[i])
						slot = i;
				end
				for (int i = 0; i < ENTRIES; i++) begin
					if (cache_live[i])
						cache_age[i]++;
				end
				cache_key[slot]  = k;
				cache_val[slot]  = v;
				cache_live[slot] = 1'b1;
				cache_age[slot]  = 0;
				cache_fill++;
			end
		end else if (e >= 0) begin
			promote(e);
			res.hit  = 1'b1;
			res.data = cache_val[e];
		end
	endfunction

	task automatic send_word(input logic c, input logic [DATA_W-1:0] k,
			input logic [DATA_W-1:0] v, input bit typed, input logic want_hit,
			input logic [DATA_W-1:0] want_data);
		bit           produced;
		read_result_t res;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		key      <= k;
		data_in  <= v;
		do @(posedge clk); while (!in_ready);
		cache_access(c, k, v, produced, res);
		if (typed) begin
			res.hit  = want_hit;
			res.data = want_data;
		end
		if (produced)
			pending_reads.push_back(res);
	endtask

	task automatic drain_reads();
		in_valid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [PDATA_W-1:0] v);
		drain_reads();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx * 4);
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_CAPACITY)
			cap_reg = v[CAP_W-1:0];
	endtask

	task automatic run_phase(input int words, input int pool_n);
		logic [DATA_W-1:0] pool [24];
		logic              c;
		logic [DATA_W-1:0] k;
		for (int i = 0; i < pool_n; i++)
			pool[i] = $urandom;
		repeat (words) begin
			c = CMD_GET;
			if ($urandom_range(1))
				c = CMD_SET;
			if ($urandom_range(9) == 0)
				k = $urandom;
			else
				k = pool[$urandom_range(pool_n - 1)];
			send_word(c, k, $urandom, 1'b0, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin : check_results
		read_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reads.size() == 0) begin
				report_mismatch($sformatf("result word with none expected: hit %b data %h",
					hit, data_out));
			end else begin
				want = pending_reads.pop_front();
				if (hit !== want.hit)
					report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
				if (data_out !== want.data)
					report_mismatch($sformatf("data_out %h, want %h", data_out, want.data));
			end
		end
	end

	initial begin
		logic [PDATA_W-1:0] cap_plan [PHASES];
		cap_plan = '{32'd16, 32'd1, 32'd0, 32'd31, 32'd8, 32'd2, 32'd17, 32'd15, 32'd3,
			32'd0, 32'd0, 32'd16, 32'd4};
		cap_plan[9]  = $urandom_range(1, 16);
		cap_plan[10] = $urandom;
		for (int i = 0; i < ENTRIES; i++) begin
			cache_live[i] = 1'b0;
			cache_age[i]  = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_REG)
				write_reg(dir_rows[r].reg_idx, dir_rows[r].value);
			else
				send_word(dir_rows[r].cmd, dir_rows[r].key, dir_rows[r].value,
					dir_rows[r].typed, dir_rows[r].want_hit, dir_rows[r].want_data);
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p == 6)
				write_reg(REG_SPARE, $urandom);
			write_reg(REG_CAPACITY, cap_plan[p]);
			idle_pct = (p == 5) ? 0 : 33;
			run_phase(PHASE_WORDS, $urandom_range(2, 24));
		end

		drain_reads();
		if (mismatch_count == 0)
			$display("lru_key_value_cache verification clean");
		else
			$display("lru_key_value_cache verification failed");
		$finish;
	end

endmodule
